// ----- rtl/core/lease_lock_table_defines.svh -----
// Assertion macros for the lease lock table.
`ifndef LEASE_LOCK_TABLE_DEFINES_SVH
`define LEASE_LOCK_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LLT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LLT_ASSERT(lbl, prop, msg)
`define LLT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/llt_pkg.sv -----
`default_nettype none
package llt_pkg;

  localparam int CmdW    = 2;
  localparam int IdW     = 32;
  localparam int NowW    = 48;
  localparam int StatusW = 3;
  localparam int ReplyW  = 32;
  localparam int LeaseW  = 32;

  localparam logic [CmdW-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CmdW-1:0] CMD_RELEASE = 2'd1;

  localparam logic [LeaseW-1:0] LEASE_RESET = 32'd1000000;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_NOENT = 3'd1,
    ST_RETRY = 3'd2,
    ST_BUSY  = 3'd3,
    ST_FULL  = 3'd4
  } llt_status_t;

  typedef struct packed {
    logic load_req;
    logic rd_issue;
    logic step_idx;
    logic set_hit;
    logic commit;
  } llt_ctl_t;

  typedef struct packed {
    logic req_stat;
    logic scan_done;
    logic key_match;
  } llt_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/llt_if.sv -----
`default_nettype none
interface llt_in_if;
  logic                      valid;
  logic                      ready;
  logic [llt_pkg::CmdW-1:0]  cmd;
  logic [llt_pkg::IdW-1:0]   lock_id;
  logic [llt_pkg::NowW-1:0]  now;

  modport source (output valid, output cmd, output lock_id, output now, input ready);
  modport sink (input valid, input cmd, input lock_id, input now, output ready);
endinterface

interface llt_out_if;
  logic                         valid;
  logic                         ready;
  logic [llt_pkg::StatusW-1:0]  status;
  logic [llt_pkg::ReplyW-1:0]   reply_value;

  modport source (output valid, output status, output reply_value, input ready);
  modport sink (input valid, input status, input reply_value, output ready);
endinterface

interface llt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [llt_pkg::LeaseW-1:0]  lease_ticks;

  modport source (output valid, output lease_ticks, input ready);
  modport sink (input valid, input lease_ticks, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lease_lock_table.sv -----
// Channel   Dir  Payload                   Handshake
// in_chan   in   cmd, lock_id, now         valid/ready
// out_chan  out  status, reply_value       valid/ready
// cfg_chan  in   lease_ticks               valid/ready, ready always high
//
// From accept to out_valid: stat passes S_SCAN then S_EVAL; acquire and release read one
// slot per S_SCAN/S_CMP pass until a key match (hit) or the fill count (miss), then S_EVAL.
// The next item can be taken in the cycle after a result is loaded.
// Reset runs no clearing pass: a fill count marks the slots in use.
// With out_ready low the result waits in the output register; the next item is taken
// and scanned meanwhile and commits once that register drains.
`default_nettype none
`include "lease_lock_table_defines.svh"
module lease_lock_table #(
  parameter int LOCK_SLOTS = 16,
  parameter int ID_BITS    = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  llt_in_if.sink     in_chan,
  llt_out_if.source  out_chan,
  llt_cfg_if.sink    cfg_chan
);
  import llt_pkg::*;

  llt_ctl_t ctl;
  llt_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign cfg_chan.ready = 1'b1;

  llt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  llt_dpath #(
    .LOCK_SLOTS (LOCK_SLOTS),
    .ID_BITS    (ID_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_cmd          (in_chan.cmd),
    .in_lock_id      (in_chan.lock_id),
    .in_now          (in_chan.now),
    .cfg_valid       (cfg_chan.valid),
    .cfg_lease_ticks (cfg_chan.lease_ticks),
    .out_status      (out_chan.status),
    .out_reply_value (out_chan.reply_value)
  );

  `LLT_ASSERT(a_busy_after_accept, in_chan.valid && in_ready |=> !in_ready, "ready after accept")
  `LLT_ASSERT(a_commit_free, ctl.commit |-> (!out_valid || out_chan.ready), "result overwritten")
  `LLT_ASSERT(a_read_in_fill, ctl.rd_issue |-> !sts.scan_done, "read past fill count")
  `LLT_ASSERT_RST(a_reset_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule
`default_nettype wire

// ----- rtl/core/llt_ctrl.sv -----
`default_nettype none
module llt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire llt_pkg::llt_sts_t sts,
  output llt_pkg::llt_ctl_t      ctl
);
  import llt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_EVAL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_req = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.req_stat || sts.scan_done) begin
          state_nxt = S_EVAL;
        end else begin
          ctl.rd_issue = 1'b1;
          state_nxt    = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.key_match) begin
          ctl.set_hit = 1'b1;
          state_nxt   = S_EVAL;
        end else begin
          ctl.step_idx = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/llt_dpath.sv -----
`default_nettype none
module llt_dpath #(
  parameter int LOCK_SLOTS = 16,
  parameter int ID_BITS    = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire llt_pkg::llt_ctl_t             ctl,
  output llt_pkg::llt_sts_t                  sts,
  input  wire logic [llt_pkg::CmdW-1:0]      in_cmd,
  input  wire logic [llt_pkg::IdW-1:0]       in_lock_id,
  input  wire logic [llt_pkg::NowW-1:0]      in_now,
  input  wire logic                          cfg_valid,
  input  wire logic [llt_pkg::LeaseW-1:0]    cfg_lease_ticks,
  output logic [llt_pkg::StatusW-1:0]        out_status,
  output logic [llt_pkg::ReplyW-1:0]         out_reply_value
);
  import llt_pkg::*;

  localparam int KeyW  = (ID_BITS < IdW) ? ID_BITS : IdW;
  localparam int WordW = KeyW + NowW;
  localparam int IW    = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
  localparam int CW    = $clog2(LOCK_SLOTS + 1);

  logic [WordW-1:0]  slot_mem_r [LOCK_SLOTS];
  logic [WordW-1:0]  rd_word_r;

  logic [CmdW-1:0]   cmd_r;
  logic [IdW-1:0]    id_r;
  logic [NowW-1:0]   now_r;
  logic [LeaseW-1:0] lease_r;
  logic [CW-1:0]     idx_r;
  logic [CW-1:0]     fill_r;
  logic [CW-1:0]     fill_nxt;
  logic [ReplyW-1:0] held_r;
  logic [ReplyW-1:0] held_nxt;
  logic              hit_r;
  llt_status_t       status_r;
  llt_status_t       status_nxt;
  logic [ReplyW-1:0] reply_r;
  logic [ReplyW-1:0] reply_nxt;

  logic [KeyW-1:0]   key_q;
  logic [NowW-1:0]   stamp_q;
  logic [NowW:0]     expiry;
  logic              lapsed;
  logic              full;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [NowW-1:0]   wr_stamp;

  assign key_q   = id_r[KeyW-1:0];
  assign stamp_q = rd_word_r[NowW-1:0];
  assign expiry  = {1'b0, stamp_q} + {{(NowW + 1 - LeaseW){1'b0}}, lease_r};
  assign lapsed  = (stamp_q == '0) || (expiry <= {1'b0, now_r});
  assign full    = (fill_r == CW'(LOCK_SLOTS));

  assign sts.req_stat  = (cmd_r != CMD_ACQUIRE) && (cmd_r != CMD_RELEASE);
  assign sts.scan_done = (idx_r == fill_r);
  assign sts.key_match = (rd_word_r[WordW-1:NowW] == key_q);

  assign out_status      = status_r;
  assign out_reply_value = reply_r;

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = idx_r[IW-1:0];
    wr_stamp   = now_r;
    status_nxt = ST_OK;
    reply_nxt  = id_r;
    held_nxt   = held_r;
    fill_nxt   = fill_r;
    case (cmd_r)
      CMD_ACQUIRE: begin
        if (hit_r) begin
          if (lapsed) begin
            wr_en    = 1'b1;
            held_nxt = held_r + ReplyW'(1);
          end else begin
            status_nxt = ST_BUSY;
          end
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en    = 1'b1;
          wr_addr  = fill_r[IW-1:0];
          fill_nxt = fill_r + CW'(1);
          held_nxt = held_r + ReplyW'(1);
        end
      end
      CMD_RELEASE: begin
        if (!hit_r) begin
          status_nxt = ST_NOENT;
        end else if (stamp_q == '0) begin
          status_nxt = ST_RETRY;
        end else begin
          wr_en    = 1'b1;
          wr_stamp = '0;
          held_nxt = held_r - ReplyW'(1);
        end
      end
      default: reply_nxt = held_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && wr_en) begin
      slot_mem_r[wr_addr] <= {key_q, wr_stamp};
    end
    if (ctl.rd_issue) begin
      rd_word_r <= slot_mem_r[idx_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      cmd_r <= in_cmd;
      id_r  <= in_lock_id;
      now_r <= in_now;
    end
    if (ctl.commit) begin
      status_r <= status_nxt;
      reply_r  <= reply_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lease_r <= LEASE_RESET;
      fill_r  <= '0;
      held_r  <= '0;
      idx_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        lease_r <= cfg_lease_ticks;
      end
      if (ctl.load_req) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else if (ctl.step_idx) begin
        idx_r <= idx_r + CW'(1);
      end else if (ctl.set_hit) begin
        hit_r <= 1'b1;
      end
      if (ctl.commit) begin
        fill_r <= fill_nxt;
        held_r <= held_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_lease_lock_table.sv -----
`default_nettype none
module tb_lease_lock_table;
  timeunit 1ns;
  timeprecision 1ps;

  import llt_pkg::*;

  localparam int SLOTS = 16;
  localparam int POOL_SIZE = 22;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 60;
  localparam logic [CmdW-1:0] CMD_STAT  = 2'd2;
  localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;
  localparam logic [NowW-1:0] NOW_MAX   = {NowW{1'b1}};

  typedef struct packed {
    llt_status_t        status;
    logic [ReplyW-1:0]  reply_value;
  } lock_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  llt_in_if  in_ch ();
  llt_out_if out_ch ();
  llt_cfg_if cfg_ch ();

  lease_lock_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // lock table mirror
  logic              slot_used [SLOTS];
  logic [IdW-1:0]    slot_key [SLOTS];
  logic [NowW-1:0]   slot_stamp [SLOTS];
  logic [ReplyW-1:0] held_model = '0;
  logic [LeaseW-1:0] lease_model = LEASE_RESET;

  lock_reply_t pending_replies [$];
  lock_reply_t want;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  logic           tx_idle_en = 1'b1;
  logic           rx_idle_en = 1'b1;
  int unsigned    hold_req_cnt = 0;
  int unsigned    hold_seen = 0;
  int unsigned    hold_left = 0;
  int unsigned    stall_left = 0;
  logic [IdW-1:0] key_pool [POOL_SIZE];
  logic [NowW-1:0] tick;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_stamp[i] = '0;
    end
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic lock_reply_t predict_reply(input logic [CmdW-1:0] cmd,
                                                input logic [IdW-1:0] id,
                                                input logic [NowW-1:0] now);
    lock_reply_t r;
    int hit;
    int free_idx;
    logic [63:0] deadline;
    r.status = ST_OK;
    r.reply_value = id;
    hit = -1;
    free_idx = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_key[i] == id && hit < 0) hit = i;
      if (!slot_used[i] && free_idx < 0) free_idx = i;
    end
    case (cmd)
      CMD_ACQUIRE: begin
        if (hit < 0) begin
          if (free_idx < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_used[free_idx] = 1'b1;
            slot_key[free_idx] = id;
            slot_stamp[free_idx] = now;
            held_model = held_model + ReplyW'(1);
          end
        end else begin
          deadline = 64'(slot_stamp[hit]) + 64'(lease_model);
          if (slot_stamp[hit] == '0 || deadline <= 64'(now)) begin
            slot_stamp[hit] = now;
            held_model = held_model + ReplyW'(1);
          end else begin
            r.status = ST_BUSY;
          end
        end
      end
      CMD_RELEASE: begin
        if (hit < 0) begin
          r.status = ST_NOENT;
        end else if (slot_stamp[hit] == '0) begin
          r.status = ST_RETRY;
        end else begin
          slot_stamp[hit] = '0;
          held_model = held_model - ReplyW'(1);
        end
      end
      default: begin
        r.reply_value = held_model;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) lease_model = cfg_ch.lease_ticks;
      if (in_ch.valid && in_ch.ready)
        pending_replies.push_back(predict_reply(in_ch.cmd, in_ch.lock_id, in_ch.now));
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_replies.size() == 0) begin
          report_error("result with no request pending");
        end else begin
          want = pending_replies.pop_front();
          if (out_ch.status !== want.status)
            report_error($sformatf("status %0d, expected %0d", out_ch.status, want.status));
          if (out_ch.reply_value !== want.reply_value)
            report_error($sformatf("reply_value %h, expected %h",
                                   out_ch.reply_value, want.reply_value));
        end
      end
    end
  end

  // result side: random stalls plus long hold-offs on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [IdW-1:0] id,
                           input logic [NowW-1:0] now);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.lock_id <= id;
    in_ch.now <= now;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_seen != items_sent);
  endtask

  task automatic write_lease(input logic [LeaseW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.lease_ticks <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_item(input int unsigned inc_max);
    int unsigned pick;
    logic [CmdW-1:0] c;
    logic [IdW-1:0] id;
    logic [NowW-1:0] t;
    tick = tick + NowW'($urandom_range(0, inc_max));
    pick = $urandom_range(0, 99);
    id = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    t = tick;
    if (pick < 45) begin
      c = CMD_ACQUIRE;
    end else if (pick < 80) begin
      c = CMD_RELEASE;
    end else if (pick < 92) begin
      c = ($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_STAT;
      id = $urandom;
    end else begin
      c = $urandom_range(0, 1) ? CMD_ACQUIRE : CMD_RELEASE;
      id = $urandom;
      if ($urandom_range(0, 3) == 0) t = {16'($urandom), 32'($urandom)};
    end
    send_item(c, id, t);
  endtask

  task automatic test_lock_basics();
    send_item(CMD_STAT, 32'h0, 48'd1);
    send_item(CMD_RELEASE, key_pool[0], 48'd5);
    send_item(CMD_ACQUIRE, key_pool[0], 48'd10);
    send_item(CMD_ACQUIRE, key_pool[0], 48'd20);
    send_item(CMD_RELEASE, key_pool[0], 48'd21);
    send_item(CMD_RELEASE, key_pool[0], 48'd22);
    send_item(CMD_ACQUIRE, key_pool[0], 48'd30);
    send_item(CMD_ACQUIRE, key_pool[0], 48'd1000029);
    send_item(CMD_ACQUIRE, key_pool[0], 48'd1000030);
    send_item(CMD_SPARE, 32'hFFFF_FFFF, 48'd1000031);
    wait_drain();
  endtask

  task automatic test_zero_tick();
    send_item(CMD_ACQUIRE, key_pool[1], 48'd0);
    send_item(CMD_ACQUIRE, key_pool[1], 48'd0);
    send_item(CMD_RELEASE, key_pool[1], 48'd0);
    wait_drain();
  endtask

  task automatic test_zero_lease();
    write_lease(32'd0);
    send_item(CMD_ACQUIRE, key_pool[0], 48'd1000100);
    send_item(CMD_ACQUIRE, key_pool[0], 48'd1000100);
    wait_drain();
  endtask

  task automatic test_lease_overflow();
    write_lease(32'hFFFF_FFFF);
    send_item(CMD_ACQUIRE, key_pool[2], NOW_MAX - NowW'(1));
    send_item(CMD_ACQUIRE, key_pool[2], NOW_MAX);
    send_item(CMD_RELEASE, key_pool[2], NOW_MAX);
    send_item(CMD_STAT, 32'hFFFF_FFFF, NOW_MAX);
    wait_drain();
  endtask

  task automatic test_random_traffic(input logic [LeaseW-1:0] lease, input int count,
                                     input int unsigned inc_max);
    write_lease(lease);
    repeat (count) random_item(inc_max);
    wait_drain();
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_req_cnt <= hold_req_cnt + 1;
    repeat (24) random_item(40);
    wait_drain();
    tx_idle_en = 1'b1;
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.cmd <= '0;
    in_ch.lock_id <= '0;
    in_ch.now <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.lease_ticks <= '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_lock_basics();
    test_zero_tick();
    test_zero_lease();
    test_lease_overflow();

    tick = 48'd2000000;
    test_random_traffic(32'd1, 100, 3);
    test_random_traffic(LeaseW'($urandom_range(20, 200)), 150, 40);
    test_backpressure();
    tick = {16'($urandom_range(16'h8000, 16'hFFF0)), 32'($urandom)};
    test_random_traffic({1'b1, 31'($urandom)}, 120, 32'hFFFF_FFFF);

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    tick = 48'd5000000;
    test_random_traffic(LEASE_RESET, 60, 400000);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_replies.size()));
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/llt_pkg.sv
rtl/core/llt_if.sv
rtl/core/llt_ctrl.sv
rtl/core/llt_dpath.sv
rtl/core/lease_lock_table.sv
tb/tb_lease_lock_table.sv
